/* rtl/lru_key_value_cache_unit_defines.svh */
// Assertion macros for the cache RTL, used by the tag and LRU block.
`ifndef LRU_KEY_VALUE_CACHE_UNIT_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define LKVC_ASSERT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("cache assertion failed");
`define LKVC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("cache assertion failed");
`else
`define LKVC_ASSERT(lbl, clk, rstn, ante, cons)
`define LKVC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

/* rtl/lkvc_pkg.sv */
`default_nettype none
package lkvc_pkg;
  localparam int ENTRIES = 16;
  localparam int IDX_W = $clog2(ENTRIES);
  localparam int OCC_W = $clog2(ENTRIES + 1);
  localparam int CAP_W = 5;
  localparam int LIM_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;
  localparam int DATA_W = 32;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;
  localparam logic [DATA_W-1:0] MISS_VALUE = '1;

  typedef struct packed {
    logic hit;
    logic [IDX_W-1:0] slot;
  } lkvc_look_t;
endpackage
`default_nettype wire

/* rtl/lkvc_req_if.sv */
`default_nettype none
interface lkvc_req_if;
  logic valid;
  logic ready;
  logic operation;
  logic signed [31:0] lookup_key;
  logic signed [31:0] write_value;
  modport source (output valid, operation, lookup_key, write_value, input ready);
  modport sink (input valid, operation, lookup_key, write_value, output ready);
endinterface
`default_nettype wire

/* rtl/lkvc_rsp_if.sv */
`default_nettype none
interface lkvc_rsp_if;
  logic valid;
  logic ready;
  logic hit;
  logic signed [31:0] read_value;
  modport source (output valid, hit, read_value, input ready);
  modport sink (input valid, hit, read_value, output ready);
endinterface
`default_nettype wire

/* rtl/lkvc_value_ram.sv */
`default_nettype none
module lkvc_value_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]              rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[addr_i];
    end
  end
endmodule
`default_nettype wire

/* rtl/lkvc_tag_lru.sv */
`default_nettype none
`include "lru_key_value_cache_unit_defines.svh"
module lkvc_tag_lru (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         look_en_i,
  input  wire logic                         op_i,
  input  wire logic [31:0]                  key_i,
  input  wire logic [lkvc_pkg::CAP_W-1:0]   cap_i,
  output lkvc_pkg::lkvc_look_t              look_o
);
  import lkvc_pkg::*;

  logic [31:0]      keys_q [ENTRIES];
  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [IDX_W-1:0] rank_q [ENTRIES];
  logic [IDX_W-1:0] rank_d [ENTRIES];
  logic [OCC_W-1:0] occ_q, occ_d;
  logic [ENTRIES-1:0] match, worst, valid_left;
  logic [LIM_W-1:0] lim;
  logic             full;
  logic             hit;
  logic [IDX_W-1:0] hit_slot, free_slot, target;
  logic [IDX_W-1:0] target_rank;
  logic             update, insert;

  always_comb begin
    match = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid_q[i] && (keys_q[i] == key_i);
    end
    hit = |match;
    hit_slot = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_slot = IDX_W'(i);
      end
    end
  end

  always_comb begin
    if (cap_i == '0) begin
      lim = LIM_W'(1);
    end else if (LIM_W'(cap_i) > LIM_W'(ENTRIES)) begin
      lim = LIM_W'(ENTRIES);
    end else begin
      lim = LIM_W'(cap_i);
    end
    full = LIM_W'(occ_q) >= lim;
  end

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      worst[i] = valid_q[i];
      for (int j = 0; j < ENTRIES; j++) begin
        if (j != i && valid_q[j] && rank_q[j] > rank_q[i]) begin
          worst[i] = 1'b0;
        end
      end
    end
    valid_left = full ? (valid_q & ~worst) : valid_q;
    free_slot = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_left[i]) begin
        free_slot = IDX_W'(i);
      end
    end
  end

  assign insert = look_en_i && !hit && (op_i == OP_PUT);
  assign update = (look_en_i && hit) || insert;
  assign target = hit ? hit_slot : free_slot;
  assign target_rank = rank_q[target];

  always_comb begin
    valid_d = valid_q;
    occ_d = occ_q;
    for (int j = 0; j < ENTRIES; j++) begin
      rank_d[j] = rank_q[j];
      if (update) begin
        if (rank_q[j] < target_rank) begin
          rank_d[j] = rank_q[j] + IDX_W'(1);
        end
        if (IDX_W'(j) == target) begin
          rank_d[j] = '0;
        end
      end
    end
    if (insert) begin
      valid_d = valid_left;
      valid_d[target] = 1'b1;
      if (!full) begin
        occ_d = occ_q + OCC_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      occ_q <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= IDX_W'(i);
      end
    end else begin
      valid_q <= valid_d;
      occ_q <= occ_d;
      rank_q <= rank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (insert) begin
      keys_q[target] <= key_i;
    end
  end

  assign look_o.hit = hit;
  assign look_o.slot = target;

  `LKVC_ASSERT(a_occ_count, clk_i, rst_ni, 1'b1, $countones(valid_q) == int'(occ_q))
  `LKVC_ASSERT(a_single_match, clk_i, rst_ni, look_en_i, $onehot0(match))
  `LKVC_ASSERT_NEXT(a_insert_valid, clk_i, rst_ni, insert, valid_q[$past(target)])
endmodule
`default_nettype wire

/* rtl/lru_key_value_cache_unit.sv */
// A transaction accepted by the request port goes through the tag lookup and value RAM
// read (ST_LOOK), then into the output register (ST_DONE), which waits for a free output.
// New transactions are accepted only in ST_IDLE, or in ST_DONE as the result is loaded.
// Reset clears all valid marks, the occupancy count and the pending result;
// recency ranks return to slot order and the capacity register to 16.
`default_nettype none
module lru_key_value_cache_unit (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [lkvc_pkg::CAP_W-1:0] cfg_wdata_i,
  lkvc_req_if.sink                        req,
  lkvc_rsp_if.source                      rsp
);
  import lkvc_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOOK = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [CAP_W-1:0]  cap_q;
  logic              op_q;
  logic [31:0]       key_q, val_q;
  logic              hit_q, get_q;
  logic              out_valid_q;
  logic              out_hit_q;
  logic [31:0]       out_value_q;
  logic              out_free, accept, look_en, load_out;
  logic [DATA_W-1:0] rdata;
  lkvc_look_t        look;

  assign out_free = !out_valid_q || rsp.ready;
  assign req.ready = (state_q == ST_IDLE) || ((state_q == ST_DONE) && out_free);
  assign accept = req.valid && req.ready;
  assign look_en = (state_q == ST_LOOK);
  assign load_out = (state_q == ST_DONE) && out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: state_d = ST_DONE;
      ST_DONE: begin
        if (load_out) begin
          state_d = accept ? ST_LOOK : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cap_q <= CAP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= req.operation;
      key_q <= req.lookup_key;
      val_q <= req.write_value;
    end
    if (look_en) begin
      hit_q <= look.hit;
      get_q <= (op_q == OP_GET);
    end
    if (load_out) begin
      out_hit_q <= hit_q;
      out_value_q <= (hit_q && get_q) ? rdata : MISS_VALUE;
    end
  end

  lkvc_tag_lru u_tag (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .look_en_i (look_en),
    .op_i      (op_q),
    .key_i     (key_q),
    .cap_i     (cap_q),
    .look_o    (look)
  );

  lkvc_value_ram #(
    .DEPTH (ENTRIES),
    .WIDTH (DATA_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (look_en && (op_q == OP_PUT)),
    .re_i    (look_en),
    .addr_i  (look.slot),
    .wdata_i (val_q),
    .rdata_o (rdata)
  );

  assign rsp.valid = out_valid_q;
  assign rsp.hit = out_hit_q;
  assign rsp.read_value = out_value_q;
endmodule
`default_nettype wire

/* dv/lru_key_value_cache_unit_tb.sv */
`default_nettype none
module lru_key_value_cache_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lkvc_pkg::*;

  typedef struct {
    logic hit;
    logic [DATA_W-1:0] value;
  } lookup_result_t;

  class lru_scoreboard;
    logic [DATA_W-1:0] keys[ENTRIES];
    logic [DATA_W-1:0] values[ENTRIES];
    bit used[ENTRIES];
    int unsigned rank[ENTRIES];
    int unsigned filled;
    int unsigned cap_reg;
    lookup_result_t pending_q[$];
    int unsigned errors;
    int unsigned hits;
    int unsigned evictions;
    int unsigned checked;

    function void clear();
      for (int i = 0; i < ENTRIES; i++) begin
        used[i] = 0;
        rank[i] = i;
      end
      filled = 0;
      cap_reg = CAP_RESET;
      pending_q.delete();
      errors = 0;
      hits = 0;
      evictions = 0;
      checked = 0;
    endfunction

    function void make_recent(int s);
      int unsigned r;
      r = rank[s];
      for (int j = 0; j < ENTRIES; j++) begin
        if (rank[j] < r) rank[j]++;
      end
      rank[s] = 0;
    endfunction

    function void note_request(logic op, logic [DATA_W-1:0] k, logic [DATA_W-1:0] v);
      lookup_result_t res;
      int s;
      int unsigned lim;
      int unsigned worst;
      bit found;
      s = 0;
      found = 0;
      for (int i = 0; i < ENTRIES; i++) begin
        if (!found && used[i] && keys[i] == k) begin
          s = i;
          found = 1;
        end
      end
      res.hit = found;
      res.value = MISS_VALUE;
      if (found) begin
        hits++;
        if (op == OP_GET) res.value = values[s];
        else values[s] = v;
        make_recent(s);
      end else if (op == OP_PUT) begin
        lim = (cap_reg == 0) ? 1 : ((cap_reg > ENTRIES) ? ENTRIES : cap_reg);
        if (filled >= lim) begin
          found = 0;
          worst = 0;
          for (int i = 0; i < ENTRIES; i++) begin
            if (used[i] && (!found || rank[i] > worst)) begin
              worst = rank[i];
              s = i;
              found = 1;
            end
          end
          if (found) begin
            used[s] = 0;
            if (filled > 0) filled--;
            evictions++;
          end
        end
        found = 0;
        for (int i = 0; i < ENTRIES; i++) begin
          if (!found && !used[i]) begin
            s = i;
            found = 1;
          end
        end
        keys[s] = k;
        values[s] = v;
        used[s] = 1;
        make_recent(s);
        filled++;
      end
      pending_q.push_back(res);
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_result(logic h, logic [DATA_W-1:0] v);
      lookup_result_t e;
      checked++;
      if (pending_q.size() == 0) begin
        report("result with nothing outstanding");
        return;
      end
      e = pending_q.pop_front();
      if (h !== e.hit) report($sformatf("hit %0b, expected %0b", h, e.hit));
      if (v !== e.value) report($sformatf("read_value %h, expected %h", v, e.value));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CAP_W-1:0] cfg_wdata_i;
  lkvc_req_if req ();
  lkvc_rsp_if rsp ();

  lru_key_value_cache_unit u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .req(req.sink), .rsp(rsp.source)
  );

  lru_scoreboard sb;
  bit idle_off;
  bit hold_rsp;
  int unsigned cycles;
  logic [DATA_W-1:0] key_pool[8];

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  initial begin
    sb = new();
    sb.clear();
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("lru_key_value_cache_unit regression: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp.valid && rsp.ready) sb.check_result(rsp.hit, rsp.read_value);
  end

  initial begin : rsp_side
    int n;
    rsp.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_rsp) begin
        rsp.ready <= 1'b0;
      end else if (!idle_off && $urandom_range(0, 5) == 0) begin
        rsp.ready <= 1'b0;
        n = $urandom_range(1, 7);
        repeat (n - 1) @(posedge clk_i);
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  task automatic send(logic op, logic [DATA_W-1:0] k, logic [DATA_W-1:0] v);
    int n;
    if (!idle_off && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 7);
      req.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    req.valid <= 1'b1;
    req.operation <= op;
    req.lookup_key <= k;
    req.write_value <= v;
    do @(posedge clk_i); while (!req.ready);
    sb.note_request(op, k, v);
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_capacity(int unsigned c);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= c[CAP_W-1:0];
    @(posedge clk_i);
    sb.cap_reg = c[CAP_W-1:0];
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [DATA_W-1:0] pick_key();
    if ($urandom_range(0, 9) == 0) return $urandom();
    return key_pool[$urandom_range(0, 7)];
  endfunction

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) begin
      send($urandom_range(0, 1), pick_key(), $urandom());
    end
  endtask

  initial begin
    cycles = 0;
    idle_off = 0;
    hold_rsp = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    req.valid = 1'b0;
    req.operation = OP_GET;
    req.lookup_key = '0;
    req.write_value = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(OP_GET, 32'h0000_0000, 32'h0);
    send(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(OP_PUT, 32'h0000_0000, 32'h0000_0000);
    send(OP_GET, 32'h8000_0000, 32'h1234_5678);
    send(OP_GET, 32'hFFFF_FFFF, 32'h0);
    send(OP_PUT, 32'h7FFF_FFFF, 32'h5555_AAAA);
    send(OP_GET, 32'h7FFF_FFFF, 32'h0);
    send(OP_GET, 32'h1111_1111, 32'h0);
    for (int i = 0; i < 18; i++) send(OP_PUT, 32'h100 + i, 32'hA000 + i);
    send(OP_GET, 32'h100, 32'h0);
    send(OP_GET, 32'h111, 32'h0);

    set_capacity(0);
    send(OP_PUT, 32'h42, 32'h1);
    send(OP_GET, 32'h111, 32'h0);
    send(OP_PUT, 32'h43, 32'h2);
    send(OP_GET, 32'h42, 32'h0);
    set_capacity(31);

    for (int p = 0; p < 8; p++) begin
      for (int j = 0; j < 8; j++) key_pool[j] = $urandom();
      if (p < 7) set_capacity((p == 0) ? 1 : (p == 1) ? 16 : $urandom_range(0, 31));
      else set_capacity(3);
      if (p == 2) begin
        fork
          begin
            hold_rsp = 1;
            repeat (60) @(posedge clk_i);
            hold_rsp = 0;
          end
          random_phase(20);
        join
      end
      if (p == 6) idle_off = 1;
      random_phase(230);
      if (p == 4) drain();
    end

    drain();
    repeat (10) @(posedge clk_i);
    $display("Checked %0d results: %0d hits, %0d evictions, with capacity settings %s",
             sb.checked, sb.hits, sb.evictions, "including zero and values above 16.");
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("lru_key_value_cache_unit regression: pass");
    end else begin
      $display("lru_key_value_cache_unit regression: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire
